/* hdl/tmcs_pkg.sv */
`default_nettype none
package tmcs_pkg;

	localparam int LEVEL_BITS = 5;
	localparam int ROW_BITS = 20;
	localparam int LEVEL_PITCH_BITS = 36;
	localparam int TOTAL_BITS = 40;

	// PVRTC format codes
	localparam logic [5:0] FMT_PVRTC_8X8_A = 6'd42;
	localparam logic [5:0] FMT_PVRTC_16X8_A = 6'd43;
	localparam logic [5:0] FMT_PVRTC_8X8_B = 6'd44;
	localparam logic [5:0] FMT_PVRTC_16X8_B = 6'd45;

	// floor(x / d) == (x * RECIP_d) >> RECIP_SHIFT for every x below 2^17
	localparam int RECIP_SHIFT = 21;
	localparam logic [17:0] RECIP_10 = 18'd209716;
	localparam logic [17:0] RECIP_12 = 18'd174763;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [2:0] bytes_log2;
		logic [3:0] dim;
	} blk_t;

	typedef struct packed {
		logic start;
		logic issue;
		logic last;
		logic [LEVEL_BITS-1:0] level;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] last_level;
		logic last_done;
		logic out_free;
	} sts_t;

	function automatic blk_t blk_lookup(input logic [5:0] fmt);
		blk_t b;
		b = '{bytes_log2: 3'd0, dim: 4'd0};
		unique case (fmt)
			6'd1: b = '{3'd0, 4'd1};
			6'd2, 6'd12, 6'd15, 6'd16: b = '{3'd2, 4'd1};
			6'd3, 6'd4, 6'd5, 6'd14: b = '{3'd1, 4'd1};
			6'd10, 6'd13: b = '{3'd3, 4'd1};
			6'd11: b = '{3'd4, 4'd1};
			6'd30, 6'd46: b = '{3'd3, 4'd4};
			6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd47, 6'd51: b = '{3'd4, 4'd4};
			6'd42, 6'd44: b = '{3'd1, 4'd2};
			6'd43, 6'd45: b = '{3'd1, 4'd4};
			6'd48, 6'd52: b = '{3'd4, 4'd8};
			6'd49, 6'd53: b = '{3'd4, 4'd10};
			6'd50, 6'd54: b = '{3'd4, 4'd12};
			default: b = '{3'd0, 4'd0};
		endcase
		return b;
	endfunction

	// Whole blocks covering n texels; n is at least 1, a zero dim gives 0
	function automatic logic [15:0] ceil_blocks(input logic [15:0] n, input logic [3:0] dim);
		logic [16:0] x;
		logic [34:0] p;
		logic [15:0] r;
		x = 17'(n) + 17'(dim) - 17'd1;
		p = '0;
		r = '0;
		unique case (dim)
			4'd1: r = x[15:0];
			4'd2: r = x[16:1];
			4'd4: r = 16'(x >> 2);
			4'd8: r = 16'(x >> 3);
			4'd10: begin
				p = 35'(x) * 35'(RECIP_10);
				r = 16'(p >> RECIP_SHIFT);
			end
			4'd12: begin
				p = 35'(x) * 35'(RECIP_12);
				r = 16'(p >> RECIP_SHIFT);
			end
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* hdl/texture_mip_chain_size_top.sv */
`default_nettype none
// channel   | handshake                  | payload
// ----------+----------------------------+----------------------------------------------
// query     | query_valid / query_stall  | format, width, height, mip_levels, query_level
// result    | result_valid / result_stall| row_pitch, level_pitch, total_size, bad_format
//
// A request walks n = max(mip_levels, query_level + 1) mip levels, one per cycle through a
// three-stage level pipeline (shift, block divide, block area), then accumulates: the
// result register loads once the last level has drained, later under result_stall.
// query_stall stays high from acceptance until the result register has been loaded; a new
// request is taken while the previous result still waits under result_stall.
// Reset clears the controller and the valid flags only.
module texture_mip_chain_size_top #(
	parameter int FORMAT_COUNT = 55,
	parameter int DIM_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic query_valid,
	output logic query_stall,
	input wire logic [5:0] format,
	input wire logic [15:0] width,
	input wire logic [15:0] height,
	input wire logic [4:0] mip_levels,
	input wire logic [4:0] query_level,
	output logic result_valid,
	input wire logic result_stall,
	output logic [19:0] row_pitch,
	output logic [35:0] level_pitch,
	output logic [39:0] total_size,
	output logic bad_format
);
	import tmcs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tmcs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.query_valid(query_valid),
		.query_stall(query_stall),
		.sts(sts),
		.cmd(cmd)
	);

	tmcs_datapath #(
		.FORMAT_COUNT(FORMAT_COUNT),
		.DIM_BITS(DIM_BITS)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.format(format),
		.width(width),
		.height(height),
		.mip_levels(mip_levels),
		.query_level(query_level),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.row_pitch(row_pitch),
		.level_pitch(level_pitch),
		.total_size(total_size),
		.bad_format(bad_format)
	);

endmodule
`default_nettype wire

/* hdl/tmcs_ctrl.sv */
`default_nettype none
module tmcs_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic query_valid,
	output logic query_stall,
	input wire tmcs_pkg::sts_t sts,
	output tmcs_pkg::cmd_t cmd
);
	import tmcs_pkg::*;

	state_t state_q, state_d;
	logic [LEVEL_BITS-1:0] lvl_q, lvl_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lvl_q <= '0;
		end else begin
			state_q <= state_d;
			lvl_q <= lvl_d;
		end
	end

	always_comb begin
		state_d = state_q;
		lvl_d = lvl_q;
		cmd = '0;
		cmd.level = lvl_q;
		query_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				lvl_d = '0;
				if (query_valid) begin
					cmd.start = 1'b1;
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				// issue one mip level per cycle
				cmd.issue = 1'b1;
				cmd.last = (lvl_q == sts.last_level);
				lvl_d = lvl_q + LEVEL_BITS'(1);
				if (cmd.last)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (sts.last_done)
					state_d = ST_FINISH;
			end
			ST_FINISH: begin
				// hold until the result register is free
				if (sts.out_free) begin
					cmd.load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

/* hdl/tmcs_datapath.sv */
`default_nettype none
module tmcs_datapath #(
	parameter int FORMAT_COUNT = 55,
	parameter int DIM_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire tmcs_pkg::cmd_t cmd,
	output tmcs_pkg::sts_t sts,
	input wire logic [5:0] format,
	input wire logic [15:0] width,
	input wire logic [15:0] height,
	input wire logic [4:0] mip_levels,
	input wire logic [4:0] query_level,
	output logic result_valid,
	input wire logic result_stall,
	output logic [19:0] row_pitch,
	output logic [35:0] level_pitch,
	output logic [39:0] total_size,
	output logic bad_format
);
	import tmcs_pkg::*;

	// request registers
	logic [DIM_BITS-1:0] w_q, h_q;
	logic [LEVEL_BITS-1:0] mips_q, qlvl_q;
	logic bad_q, pvrtc_q;
	logic [2:0] bytes_log2_q;
	logic [3:0] dim_q;
	logic [4:0] min_w_q;
	logic [3:0] min_h_q;

	blk_t blk_in;
	logic bad_in, pvrtc88_in, pvrtc168_in;

	assign blk_in = blk_lookup(format);
	assign bad_in = ({1'b0, format} >= 7'(FORMAT_COUNT)) || (blk_in.dim == 4'd0);
	assign pvrtc88_in = (format == FMT_PVRTC_8X8_A) || (format == FMT_PVRTC_8X8_B);
	assign pvrtc168_in = (format == FMT_PVRTC_16X8_A) || (format == FMT_PVRTC_16X8_B);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			w_q <= width[DIM_BITS-1:0];
			h_q <= height[DIM_BITS-1:0];
			mips_q <= mip_levels;
			qlvl_q <= query_level;
			bad_q <= bad_in;
			pvrtc_q <= pvrtc88_in || pvrtc168_in;
			bytes_log2_q <= blk_in.bytes_log2;
			dim_q <= blk_in.dim;
			min_w_q <= pvrtc168_in ? 5'd16 : (pvrtc88_in ? 5'd8 : 5'd1);
			min_h_q <= (pvrtc88_in || pvrtc168_in) ? 4'd8 : 4'd1;
		end
	end

	assign sts.last_level = (mips_q > qlvl_q) ? (mips_q - LEVEL_BITS'(1)) : qlvl_q;

	// stage 1: level dimensions
	logic [15:0] raw_w, raw_h;
	logic [15:0] lw_s1, lh_s1, rw_s1;
	logic valid_s1, query_s1, sum_s1, last_s1;

	assign raw_w = (16'(w_q) >> cmd.level) == 16'd0 ? 16'd1 : (16'(w_q) >> cmd.level);
	assign raw_h = (16'(h_q) >> cmd.level) == 16'd0 ? 16'd1 : (16'(h_q) >> cmd.level);

	always_ff @(posedge clk) begin
		rw_s1 <= raw_w;
		lw_s1 <= (raw_w < 16'(min_w_q)) ? 16'(min_w_q) : raw_w;
		lh_s1 <= (raw_h < 16'(min_h_q)) ? 16'(min_h_q) : raw_h;
		query_s1 <= (cmd.level == qlvl_q);
		sum_s1 <= (cmd.level < mips_q);
		last_s1 <= cmd.last;
	end

	// stage 2: block counts
	logic [15:0] bw_s2, bh_s2, rb_s2;
	logic [15:0] rb_pow2;
	logic valid_s2, query_s2, sum_s2, last_s2;

	// PVRTC block dims are powers of two; in every format the row uses the unclamped width
	assign rb_pow2 = (dim_q == 4'd4) ? 16'((17'(rw_s1) + 17'd3) >> 2)
		: 16'((17'(rw_s1) + 17'd1) >> 1);

	always_ff @(posedge clk) begin
		bw_s2 <= ceil_blocks(lw_s1, dim_q);
		bh_s2 <= ceil_blocks(lh_s1, dim_q);
		rb_s2 <= pvrtc_q ? rb_pow2 : ceil_blocks(rw_s1, dim_q);
		query_s2 <= query_s1;
		sum_s2 <= sum_s1;
		last_s2 <= last_s1;
	end

	// stage 3: block area
	logic [31:0] area_s3;
	logic [15:0] rb_s3;
	logic valid_s3, query_s3, sum_s3, last_s3;

	always_ff @(posedge clk) begin
		area_s3 <= 32'(bw_s2) * 32'(bh_s2);
		rb_s3 <= rb_s2;
		query_s3 <= query_s2;
		sum_s3 <= sum_s2;
		last_s3 <= last_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// accumulate: bytes per block is a power of two, so the area shifts and cannot overflow
	logic [LEVEL_PITCH_BITS-1:0] pitch;
	logic [ROW_BITS-1:0] row;
	logic [TOTAL_BITS:0] sum;
	logic [TOTAL_BITS-1:0] total_q;
	logic [LEVEL_PITCH_BITS-1:0] lvl_q;
	logic [ROW_BITS-1:0] row_q;

	assign pitch = LEVEL_PITCH_BITS'(area_s3) << bytes_log2_q;
	assign row = ROW_BITS'(rb_s3) << bytes_log2_q;
	assign sum = {1'b0, total_q} + (TOTAL_BITS + 1)'(pitch);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			total_q <= '0;
		end else if (valid_s3) begin
			if (sum_s3)
				total_q <= sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
			if (query_s3) begin
				row_q <= row;
				lvl_q <= pitch;
			end
		end
	end

	assign sts.last_done = valid_s3 && last_s3;
	assign sts.out_free = !result_valid || !result_stall;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (cmd.load) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			row_pitch <= bad_q ? '0 : row_q;
			level_pitch <= bad_q ? '0 : lvl_q;
			total_size <= bad_q ? '0 : total_q;
			bad_format <= bad_q;
		end
	end

endmodule
`default_nettype wire

/* hdl/tmcs_checker.sv */
`default_nettype none
module tmcs_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic query_valid,
	input wire logic query_stall,
	input wire logic result_valid,
	input wire logic result_stall,
	input wire logic [19:0] row_pitch,
	input wire logic [35:0] level_pitch,
	input wire logic [39:0] total_size,
	input wire logic bad_format
);

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(total_size))
		else $error("stalled result dropped or changed");

	// one request at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		query_valid && !query_stall |=> query_stall)
		else $error("request accepted while previous one in flight");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && bad_format |-> row_pitch == 20'd0 && level_pitch == 36'd0
			&& total_size == 40'd0)
		else $error("bad format with nonzero sizes");

	// a good format always covers at least one block
	a_good_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !bad_format |-> row_pitch != 20'd0 && level_pitch != 36'd0)
		else $error("good format with zero pitch");

endmodule

bind texture_mip_chain_size_top tmcs_checker u_tmcs_checker (.*);
`default_nettype wire
